// File: rtl/ecpr_pkg.sv
// ----------------------------------------------------------------------------
// ecpr_pkg
// Shared types and constants of the enhanced clock page replacer.
// ----------------------------------------------------------------------------
package ecpr_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int ACTION_W      = 2;
    localparam int PID_W         = 8;
    localparam int FRAME_W       = 8;
    localparam int SLOT_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = PID_W + FRAME_W;

    // sweep phases: clean, dirty with reference clearing, clean, dirty
    localparam logic [1:0] PHASE_CLEAR = 2'd1;
    localparam logic [1:0] PHASE_LAST  = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_ACCESS  = 2'd1,
        ACT_REPLACE = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_FULL   = 2'd2,
        STAT_EMPTY_SLOT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SWEEP,
        ST_READ,
        ST_COMMIT
    } t_ctrl_state;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PID_W-1:0]    owner_pid;
        logic [FRAME_W-1:0]  frame_number;
        logic [SLOT_W-1:0]   slot_index;
        logic                is_write;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_used;
        logic [PID_W-1:0]    victim_pid;
        logic [FRAME_W-1:0]  victim_frame;
        logic                victim_dirty;
    } t_rsp;

    typedef struct packed {
        logic load_req;
        logic sweep_step;
        logic read_victim;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_sweep;
        logic sweep_end;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/ecpr_stream_if.sv
// ----------------------------------------------------------------------------
// ecpr_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface ecpr_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/enhanced_clock_page_replacer_core.sv
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer_core
// Enhanced second-chance clock page replacer. The block handles one request
// at a time. Insert, access, a refused replace and the unused action code
// pass from the check state straight to the commit state. A replace on a
// full ring adds its victim sweep, which visits one slot per cycle in up to
// four passes over the reference/dirty bits; the sweep length sets the rate.
// A result waits in an output register, and the next request is taken while
// it waits. The owner/frame store has no reset: only occupied slots are ever
// read.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer_core #(
    parameter int NUM_SLOTS = ecpr_pkg::DEF_NUM_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecpr_stream_if.sink   i_req,
    ecpr_stream_if.source o_rsp
);
    import ecpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    rsp_valid;
    t_rsp    rsp;

    ecpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ecpr_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.payload),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = rsp_valid;
    assign o_rsp.payload = rsp;

`ifndef SYNTHESIS
    // a result never lands on top of one that has not been taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result committed over an unread result");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in progress");

    // end of sweep goes straight to the victim read
    a_sweep_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.sweep_step && sts.sweep_end) |=> cmd.read_victim)
        else $error("victim read missing after sweep end");

    // a request load is never followed straight by a result commit
    a_commit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_req |=> !cmd.commit)
        else $error("result committed without request check");
`endif

endmodule

// File: rtl/ecpr_ctrl.sv
// ----------------------------------------------------------------------------
// ecpr_ctrl
// Sequencer: takes one request, runs the victim sweep when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ecpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ecpr_pkg::t_dp_sts i_sts,
    output ecpr_pkg::t_dp_cmd o_cmd
);
    import ecpr_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_sts.need_sweep ? ST_SWEEP : ST_COMMIT;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read_victim = 1'b1;
                n_state           = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ecpr_dp.sv
// ----------------------------------------------------------------------------
// ecpr_dp
// Page ring: entry memory, per-slot reference/dirty/occupied bits, clock
// hand, fill count, victim sweep pointer and the output register.
// ----------------------------------------------------------------------------
module ecpr_dp #(
    parameter int NUM_SLOTS = ecpr_pkg::DEF_NUM_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecpr_pkg::t_req    i_req,
    input  ecpr_pkg::t_dp_cmd i_cmd,
    output ecpr_pkg::t_dp_sts o_sts,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output ecpr_pkg::t_rsp    o_rsp
);
    import ecpr_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);
    localparam logic [IW:0]   SLOTS_EXT = (IW + 1)'(NUM_SLOTS);
    localparam logic [CW-1:0] SLOTS_CNT = CW'(NUM_SLOTS);

    logic [ENTRY_W-1:0]   r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_ref;
    logic [NUM_SLOTS-1:0] r_mod;
    logic [NUM_SLOTS-1:0] r_occ;
    logic [IW-1:0]        r_hand;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid;

    t_req                 r_req;
    t_rsp                 r_rsp;
    logic [IW-1:0]        r_ptr;
    logic [IW-1:0]        r_idx;
    logic [1:0]           r_phase;
    logic [IW-1:0]        r_victim;
    logic [ENTRY_W-1:0]   r_rd_data;

    logic                 full;
    logic                 cur_hit;
    logic                 sweep_last;
    logic [IW-1:0]        ptr_next;
    logic [IW:0]          ins_sum;
    logic [IW:0]          ins_wrap;
    logic [IW-1:0]        ins_slot;
    logic [IW-1:0]        acc_slot;
    logic                 acc_ok;
    logic [IW-1:0]        hand_next;
    t_rsp                 rsp_next;

    assign full       = (r_count == SLOTS_CNT);
    assign cur_hit    = r_occ[r_ptr] && !r_ref[r_ptr] && (r_mod[r_ptr] == r_phase[0]);
    assign sweep_last = (r_phase == PHASE_LAST) && (r_idx == LAST_SLOT);
    assign ptr_next   = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
    assign hand_next  = (r_victim == LAST_SLOT) ? '0 : r_victim + 1'b1;

    // insert slot is hand plus count, wrapped once
    assign ins_sum  = {1'b0, r_hand} + (IW + 1)'(r_count);
    assign ins_wrap = ins_sum - SLOTS_EXT;
    assign ins_slot = (ins_sum >= SLOTS_EXT) ? ins_wrap[IW-1:0] : ins_sum[IW-1:0];

    assign acc_slot = IW'(r_req.slot_index);
    assign acc_ok   = (32'(r_req.slot_index) < 32'(NUM_SLOTS)) && r_occ[acc_slot];

    assign o_sts.need_sweep = (r_req.action == ACT_REPLACE) && full;
    assign o_sts.sweep_end  = cur_hit || sweep_last;
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        rsp_next = '0;
        case (r_req.action)
            ACT_INSERT: begin
                if (full) begin
                    rsp_next.status = STAT_FULL;
                end else begin
                    rsp_next.status    = STAT_OK;
                    rsp_next.slot_used = SLOT_W'(ins_slot);
                end
            end
            ACT_ACCESS: begin
                rsp_next.status = acc_ok ? STAT_OK : STAT_EMPTY_SLOT;
            end
            ACT_REPLACE: begin
                if (!full) begin
                    rsp_next.status = STAT_NOT_FULL;
                end else begin
                    rsp_next.status       = STAT_OK;
                    rsp_next.slot_used    = SLOT_W'(r_victim);
                    rsp_next.victim_pid   = r_rd_data[ENTRY_W-1:FRAME_W];
                    rsp_next.victim_frame = r_rd_data[FRAME_W-1:0];
                    rsp_next.victim_dirty = r_mod[r_victim];
                end
            end
            default: begin
                rsp_next = '0;
            end
        endcase
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= '0;
            r_mod       <= '0;
            r_occ       <= '0;
            r_hand      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the dirty-class sweep gives every slot it passes a second chance
            if (i_cmd.sweep_step && !cur_hit && !sweep_last && r_phase == PHASE_CLEAR) begin
                r_ref[r_ptr] <= 1'b0;
            end
            if (i_cmd.commit) begin
                case (r_req.action)
                    ACT_INSERT: begin
                        if (!full) begin
                            r_occ[ins_slot] <= 1'b1;
                            r_ref[ins_slot] <= 1'b0;
                            r_mod[ins_slot] <= 1'b0;
                            r_count         <= r_count + 1'b1;
                        end
                    end
                    ACT_ACCESS: begin
                        if (acc_ok) begin
                            r_ref[acc_slot] <= 1'b1;
                            if (r_req.is_write) begin
                                r_mod[acc_slot] <= 1'b1;
                            end
                        end
                    end
                    ACT_REPLACE: begin
                        if (full) begin
                            r_occ[r_victim] <= 1'b0;
                            r_ref[r_victim] <= 1'b0;
                            r_mod[r_victim] <= 1'b0;
                            r_count         <= r_count - 1'b1;
                            r_hand          <= hand_next;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, sweep pointer and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_req;
            r_ptr   <= r_hand;
            r_idx   <= '0;
            r_phase <= '0;
        end
        if (i_cmd.sweep_step) begin
            if (cur_hit) begin
                r_victim <= r_ptr;
            end else if (sweep_last) begin
                r_victim <= r_hand;
            end else begin
                r_ptr <= ptr_next;
                if (r_idx == LAST_SLOT) begin
                    r_idx   <= '0;
                    r_phase <= r_phase + 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
        if (i_cmd.commit) begin
            r_rsp <= rsp_next;
        end
    end

    // entry memory: owner and frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_req.action == ACT_INSERT && !full) begin
            r_mem[ins_slot] <= {r_req.owner_pid, r_req.frame_number};
        end
        if (i_cmd.read_victim) begin
            r_rd_data <= r_mem[r_victim];
        end
    end

endmodule

// File: sim/enhanced_clock_page_replacer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer_core_test
// Drives insert, access, replace and unused-code requests into the clock
// page replacer. A scoreboard keeps its own copy of the page ring and checks
// every result in order. Idling and a long output hold-off vary across the run.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer_core_test;
    import ecpr_pkg::*;

    localparam int SLOTS        = DEF_NUM_SLOTS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 4 + 4 * SLOTS + 32;
    localparam int PRINT_CAP    = 100;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Ring contents, hand and pending results as the block should hold them.
    class ring_scoreboard;
        logic [PID_W-1:0]   page_owner [SLOTS];
        logic [FRAME_W-1:0] page_frame [SLOTS];
        bit                 ref_bit    [SLOTS];
        bit                 dirty_bit  [SLOTS];
        bit                 in_use     [SLOTS];
        int                 hand;
        int                 resident;
        t_rsp               pending_outcomes[$];
        int                 mismatches;
        int                 status_seen[4];
        int                 victims_by_pass[5];
        int                 dirty_victims;

        function new();
            foreach (in_use[i]) begin
                page_owner[i] = '0;
                page_frame[i] = '0;
                ref_bit[i]    = 0;
                dirty_bit[i]  = 0;
                in_use[i]     = 0;
            end
            hand       = 0;
            resident   = 0;
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (victims_by_pass[i]) victims_by_pass[i] = 0;
            dirty_victims = 0;
        endfunction

        task report(input string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        // Walk once around from the hand; returns SLOTS when nothing fits.
        function int sweep_for(input bit want_dirty, input bit clear_ref);
            int s;
            for (int i = 0; i < SLOTS; i++) begin
                s = (hand + i) % SLOTS;
                if (in_use[s]) begin
                    if (!ref_bit[s] && dirty_bit[s] == want_dirty)
                        return s;
                    if (clear_ref)
                        ref_bit[s] = 0;
                end
            end
            return SLOTS;
        endfunction

        function t_rsp apply_page_request(input t_req rq);
            t_rsp rs;
            int   s;
            int   pass;
            rs = '0;
            case (rq.action)
                ACT_INSERT: begin
                    if (resident >= SLOTS) begin
                        rs.status = STAT_FULL;
                    end else begin
                        s = (hand + resident) % SLOTS;
                        page_owner[s] = rq.owner_pid;
                        page_frame[s] = rq.frame_number;
                        ref_bit[s]    = 0;
                        dirty_bit[s]  = 0;
                        in_use[s]     = 1;
                        resident++;
                        rs.slot_used = SLOT_W'(s);
                    end
                end
                ACT_ACCESS: begin
                    if (int'(rq.slot_index) >= SLOTS || !in_use[rq.slot_index]) begin
                        rs.status = STAT_EMPTY_SLOT;
                    end else begin
                        ref_bit[rq.slot_index] = 1;
                        if (rq.is_write)
                            dirty_bit[rq.slot_index] = 1;
                    end
                end
                ACT_REPLACE: begin
                    if (resident < SLOTS) begin
                        rs.status = STAT_NOT_FULL;
                    end else begin
                        pass = 1;
                        s = sweep_for(1'b0, 1'b0);
                        if (s >= SLOTS) begin
                            pass = 2;
                            s = sweep_for(1'b1, 1'b1);
                        end
                        if (s >= SLOTS) begin
                            pass = 3;
                            s = sweep_for(1'b0, 1'b0);
                        end
                        if (s >= SLOTS) begin
                            pass = 4;
                            s = sweep_for(1'b1, 1'b0);
                        end
                        if (s >= SLOTS) begin
                            pass = 5;
                            s = hand;
                        end
                        victims_by_pass[pass-1]++;
                        if (dirty_bit[s])
                            dirty_victims++;
                        rs.slot_used    = SLOT_W'(s);
                        rs.victim_pid   = page_owner[s];
                        rs.victim_frame = page_frame[s];
                        rs.victim_dirty = dirty_bit[s];
                        in_use[s]    = 0;
                        ref_bit[s]   = 0;
                        dirty_bit[s] = 0;
                        resident--;
                        hand = (s + 1) % SLOTS;
                    end
                end
                default: ;
            endcase
            status_seen[rs.status]++;
            return rs;
        endfunction

        function void note_request(input t_req rq);
            pending_outcomes.push_back(apply_page_request(rq));
        endfunction

        task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(input t_rsp got);
            t_rsp want;
            if (pending_outcomes.size() == 0) begin
                report("result with no request pending");
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 16'(got.status), 16'(want.status));
                check_field("slot_used", 16'(got.slot_used), 16'(want.slot_used));
                check_field("victim_pid", 16'(got.victim_pid), 16'(want.victim_pid));
                check_field("victim_frame", 16'(got.victim_frame), 16'(want.victim_frame));
                check_field("victim_dirty", 16'(got.victim_dirty), 16'(want.victim_dirty));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ecpr_stream_if #(.t_payload(t_req)) req_if ();
    ecpr_stream_if #(.t_payload(t_rsp)) rsp_if ();

    enhanced_clock_page_replacer_core #(
        .NUM_SLOTS(SLOTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    ring_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rsp_hold_left  = 0;
    int cycle_count    = 0;
    int requests_sent  = 0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("enhanced_clock_page_replacer_core_test NOT OK");
            $finish;
        end
    end

    // Results first: a result taken at this edge belongs to an older request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                sb.check_result(rsp_if.payload);
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
                sb.note_request(req_if.payload);
        end
    end

    // Result side: a hold-off counts down here, otherwise stall at random.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_left > 0) begin
                rsp_hold_left--;
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input logic [ACTION_W-1:0] act, input logic [PID_W-1:0] pid,
                         input logic [FRAME_W-1:0] frame, input logic [SLOT_W-1:0] slot,
                         input logic wr);
        t_req rq;
        rq.action       = act;
        rq.owner_pid    = pid;
        rq.frame_number = frame;
        rq.slot_index   = slot;
        rq.is_write     = wr;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.payload = rq;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [SLOT_W-1:0] pick_resident_slot();
        if (sb.resident == 0)
            return SLOT_W'($urandom_range(SLOTS - 1));
        return SLOT_W'((sb.hand + $urandom_range(sb.resident - 1)) % SLOTS);
    endfunction

    // Touch most of a full ring, then evict: pushes the replace into the
    // later sweeps.
    task automatic access_storm();
        int write_pct;
        int skip_pct;
        int base;
        case ($urandom_range(2))
            0:       write_pct = 0;
            1:       write_pct = 50;
            default: write_pct = 100;
        endcase
        skip_pct = $urandom_range(1) ? 0 : 15;
        base     = sb.hand;
        for (int i = 0; i < SLOTS; i++) begin
            if ($urandom_range(99) >= skip_pct)
                issue(ACT_ACCESS, PID_W'($urandom_range(255)), FRAME_W'($urandom_range(255)),
                      SLOT_W'((base + i) % SLOTS), $urandom_range(99) < write_pct);
        end
        issue(ACT_REPLACE, PID_W'($urandom_range(255)), FRAME_W'($urandom_range(255)),
              SLOT_W'($urandom_range(SLOTS - 1)), 1'($urandom_range(1)));
    endtask

    task automatic random_request();
        int                  roll;
        logic [ACTION_W-1:0] act;
        logic [SLOT_W-1:0]   slot;
        roll = $urandom_range(99);
        slot = pick_resident_slot();
        if (sb.resident == SLOTS) begin
            if (roll < 30)      act = ACT_REPLACE;
            else if (roll < 88) act = ACT_ACCESS;
            else if (roll < 96) act = ACT_INSERT;
            else                act = ACT_UNUSED;
        end else begin
            if (roll < 55)      act = ACT_INSERT;
            else if (roll < 85) act = ACT_ACCESS;
            else if (roll < 93) begin
                act  = ACT_ACCESS;
                slot = SLOT_W'($urandom_range(SLOTS - 1));
            end
            else if (roll < 97) act = ACT_REPLACE;
            else                act = ACT_UNUSED;
        end
        issue(act, PID_W'($urandom_range(255)), FRAME_W'($urandom_range(255)), slot,
              1'($urandom_range(1)));
    endtask

    task automatic run_random(input int count);
        int target;
        target = requests_sent + count;
        while (requests_sent < target) begin
            if (sb.resident == SLOTS && $urandom_range(99) < 12)
                access_storm();
            else
                random_request();
        end
    endtask

    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Refused requests and the unused action code on an empty ring, then fill it up.
        issue(ACT_REPLACE, 8'h00, 8'h00, 4'h0, 1'b0);
        issue(ACT_ACCESS, 8'hFF, 8'hFF, 4'h0, 1'b1);
        issue(ACT_UNUSED, 8'hFF, 8'hFF, 4'hF, 1'b1);
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0)
                issue(ACT_INSERT, 8'h00, 8'h00, 4'hF, 1'b1);
            else if (i == 1)
                issue(ACT_INSERT, 8'hFF, 8'hFF, 4'h0, 1'b0);
            else
                issue(ACT_INSERT, PID_W'($urandom_range(255)), FRAME_W'($urandom_range(255)),
                      SLOT_W'($urandom_range(SLOTS - 1)), 1'($urandom_range(1)));
        end
        issue(ACT_INSERT, 8'h5A, 8'hA5, 4'h3, 1'b0);
        issue(ACT_ACCESS, 8'h00, 8'h00, 4'h0, 1'b1);
        issue(ACT_ACCESS, 8'h00, 8'h00, 4'h1, 1'b0);
        issue(ACT_REPLACE, 8'h00, 8'h00, 4'h0, 1'b0);
        issue(ACT_ACCESS, 8'h00, 8'h00, 4'h2, 1'b1);

        run_random(280);
        send_idle_pct = 46;
        run_random(280);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_random(280);

        // Hold off results long enough for the block to back up its input.
        recv_stall_pct = 0;
        rsp_hold_left  = 300;
        run_random(40);

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(280);

        req_if.valid = 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d ok, %0d full, %0d not full, %0d empty slot",
                 requests_sent, sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL],
                 sb.status_seen[STAT_NOT_FULL], sb.status_seen[STAT_EMPTY_SLOT]);
        $display("Evictions per sweep 1..4: %0d %0d %0d %0d, fallback %0d, dirty %0d",
                 sb.victims_by_pass[0], sb.victims_by_pass[1], sb.victims_by_pass[2],
                 sb.victims_by_pass[3], sb.victims_by_pass[4], sb.dirty_victims);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
            $display("enhanced_clock_page_replacer_core_test OK");
        else
            $display("enhanced_clock_page_replacer_core_test NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/ecpr_pkg.sv
rtl/ecpr_stream_if.sv
rtl/ecpr_ctrl.sv
rtl/ecpr_dp.sv
rtl/enhanced_clock_page_replacer_core.sv
sim/enhanced_clock_page_replacer_core_test.sv
